>>> design/grw_pkg.sv
`timescale 1ns / 1ps

package grw_pkg;

  localparam int POS_W   = 15;  // player position, Q11.4
  localparam int ANG_W   = 10;  // angle code
  localparam int HIT_W   = 16;  // hit pixel
  localparam int CNT_W   = 5;   // step counter and config fields
  localparam int LG_W    = 3;   // cell size log2
  localparam int STAT_W  = 2;   // cast status
  localparam int SLOPE_W = 33;  // Q16 slope, saturated to +-2^31
  localparam int DIFF_W  = 25;  // snap distance along the stepping axis, Q16
  localparam int PROD_W  = DIFF_W + SLOPE_W;
  localparam int RAY_W   = 48;  // ray point, Q16
  localparam int IDX_W   = 10;  // row * width + col, both below 32

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint SLOPE_MAX   = 64'sd2147483648;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [STAT_W-1:0] ST_WALL     = 2'd0;
  localparam logic [STAT_W-1:0] ST_LIMIT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_PARALLEL = 2'd2;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX_STEPS  = 2'd2;
  localparam logic [1:0] CFG_CELL_LG    = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] map_width;
    logic [CNT_W-1:0] map_height;
    logic [CNT_W-1:0] max_steps;
    logic [LG_W-1:0]  cell_lg;
  } grw_cfg_t;

  // per angle code: slopes for both line families, parallel flags and direction flags
  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_h;
    logic signed [SLOPE_W-1:0] slope_v;
    logic                      par_h;
    logic                      par_v;
    logic                      neg_h;
    logic                      neg_v;
  } grw_ang_t;

endpackage

>>> design/grw_tan_rom.sv
`timescale 1ns / 1ps

module grw_tan_rom #(
  parameter int ANGLE_STEPS = 1024
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [grw_pkg::ANG_W-1:0] rd_addr,
  output grw_pkg::grw_ang_t         rd_data
);
  import grw_pkg::*;

  localparam int DEPTH = 2 ** ANG_W;
  localparam int Q     = ANGLE_STEPS / 4;
  localparam int HALF  = ANGLE_STEPS / 2;

  grw_ang_t tab [DEPTH];
  grw_ang_t rd_q_r;

  function automatic longint mulq(input longint t, input longint x);
    return (t * x) >>> 30;
  endfunction

  // taylor series to the 17th power, every term truncated
  function automatic longint sin_q30(input longint x);
    longint t;
    longint acc;
    t = x;
    acc = x;
    t = mulq(t, x) / 2;  t = mulq(t, x) / 3;  acc = acc - t;
    t = mulq(t, x) / 4;  t = mulq(t, x) / 5;  acc = acc + t;
    t = mulq(t, x) / 6;  t = mulq(t, x) / 7;  acc = acc - t;
    t = mulq(t, x) / 8;  t = mulq(t, x) / 9;  acc = acc + t;
    t = mulq(t, x) / 10; t = mulq(t, x) / 11; acc = acc - t;
    t = mulq(t, x) / 12; t = mulq(t, x) / 13; acc = acc + t;
    t = mulq(t, x) / 14; t = mulq(t, x) / 15; acc = acc - t;
    t = mulq(t, x) / 16; t = mulq(t, x) / 17; acc = acc + t;
    return acc;
  endfunction

  function automatic longint cos_q30(input longint x);
    longint t;
    longint acc;
    t = 64'sd1 << 30;
    acc = t;
    t = mulq(t, x) / 1;  t = mulq(t, x) / 2;  acc = acc - t;
    t = mulq(t, x) / 3;  t = mulq(t, x) / 4;  acc = acc + t;
    t = mulq(t, x) / 5;  t = mulq(t, x) / 6;  acc = acc - t;
    t = mulq(t, x) / 7;  t = mulq(t, x) / 8;  acc = acc + t;
    t = mulq(t, x) / 9;  t = mulq(t, x) / 10; acc = acc - t;
    t = mulq(t, x) / 11; t = mulq(t, x) / 12; acc = acc + t;
    t = mulq(t, x) / 13; t = mulq(t, x) / 14; acc = acc - t;
    t = mulq(t, x) / 15; t = mulq(t, x) / 16; acc = acc + t;
    return acc;
  endfunction

  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    localparam int     A  = i % ANGLE_STEPS;
    localparam int     K  = (A / Q) % 4;
    localparam int     R  = A % Q;
    localparam longint XV = (longint'(R) * HALF_PI_Q30) / Q;
    localparam longint S0 = sin_q30(XV);
    localparam longint C0 = cos_q30(XV);
    localparam longint SN = (K == 0) ? S0 : (K == 1) ? C0 : (K == 2) ? -S0 : -C0;
    localparam longint CN = (K == 0) ? C0 : (K == 1) ? -S0 : (K == 2) ? -C0 : S0;
    localparam longint VH = (CN * 65536) / ((SN == 0) ? 1 : SN);
    localparam longint VV = (SN * 65536) / ((CN == 0) ? 1 : CN);
    localparam longint SH = (SN == 0) ? 0 :
        -((VH > SLOPE_MAX) ? SLOPE_MAX : (VH < -SLOPE_MAX) ? -SLOPE_MAX : VH);
    localparam longint SV = (CN == 0) ? 0 :
        -((VV > SLOPE_MAX) ? SLOPE_MAX : (VV < -SLOPE_MAX) ? -SLOPE_MAX : VV);
    localparam bit PAR_H = (A == 0) || (A == HALF);
    localparam bit PAR_V = (A == Q) || (A == 3 * Q);
    localparam bit NEG_H = A > HALF;
    localparam bit NEG_V = (A > Q) && (A < 3 * Q);

    assign tab[i] = '{slope_h: SLOPE_W'(SH), slope_v: SLOPE_W'(SV),
                      par_h: PAR_H, par_v: PAR_V, neg_h: NEG_H, neg_v: NEG_V};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= tab[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

>>> design/grw_wall_map.sv
`timescale 1ns / 1ps

module grw_wall_map #(
  parameter int MAP_CELLS = 256,
  localparam int AW = $clog2(MAP_CELLS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [7:0]    wr_index,
  input  logic          wr_wall,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  output logic          clearing
);

  logic          mem [MAP_CELLS];
  logic          rd_q_r;
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] wr_addr;

  // write index wraps at the map size
  if (MAP_CELLS >= 256) begin : g_nowrap
    assign wr_addr = AW'(wr_index);
  end else begin : g_wrap
    logic [AW-1:0] wrap_tab [256];
    for (genvar i = 0; i < 256; i++) begin : g_w
      localparam int WRAP = i % MAP_CELLS;
      assign wrap_tab[i] = AW'(WRAP);
    end
    assign wr_addr = wrap_tab[wr_index];
  end

  // clearing sweep after reset, one cell a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == AW'(MAP_CELLS - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_wall;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_q_r;
  assign clearing = clearing_r;

endmodule

>>> design/grw_ray_engine.sv
`timescale 1ns / 1ps

module grw_ray_engine #(
  parameter int MAP_CELLS  = 256,
  parameter int STEP_LIMIT = 31,
  localparam int AW = $clog2(MAP_CELLS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cast_go,
  input  logic [grw_pkg::POS_W-1:0]         player_x,
  input  logic [grw_pkg::POS_W-1:0]         player_y,
  input  logic                              line_family,
  input  grw_pkg::grw_cfg_t                 cfg,
  input  grw_pkg::grw_ang_t                 ang,
  output logic                              map_rd_en,
  output logic [AW-1:0]                     map_rd_addr,
  input  logic                              map_rd_data,
  output logic                              idle,
  output logic                              res_valid,
  output logic signed [grw_pkg::HIT_W-1:0]  res_hit_x,
  output logic signed [grw_pkg::HIT_W-1:0]  res_hit_y,
  output logic [grw_pkg::CNT_W-1:0]         res_steps,
  output logic [grw_pkg::STAT_W-1:0]        res_status
);
  import grw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_SNAP,
    S_CHECK,
    S_WAIT
  } state_t;

  localparam logic [LG_W-1:0]   MIN_LG      = 3'd3;
  localparam int                CMP_W       = 14;

  state_t                     state_r, state_nxt;
  logic [POS_W-1:0]           px_r, px_nxt;
  logic [POS_W-1:0]           py_r, py_nxt;
  logic                       fam_r, fam_nxt;
  logic signed [SLOPE_W-1:0]  slope_r, slope_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [RAY_W-1:0]    main_r, main_nxt;
  logic signed [RAY_W-1:0]    step_main_r, step_main_nxt;
  logic signed [RAY_W-1:0]    step_cross_r, step_cross_nxt;
  logic signed [RAY_W-1:0]    rx_r, rx_nxt;
  logic signed [RAY_W-1:0]    ry_r, ry_nxt;
  logic signed [RAY_W-1:0]    ox_r, ox_nxt;
  logic signed [RAY_W-1:0]    oy_r, oy_nxt;
  logic [CNT_W-1:0]           steps_r, steps_nxt;
  logic                       valid_r, valid_nxt;
  logic signed [HIT_W-1:0]    hx_r, hx_nxt;
  logic signed [HIT_W-1:0]    hy_r, hy_nxt;
  logic [CNT_W-1:0]           rsteps_r, rsteps_nxt;
  logic [STAT_W-1:0]          rstat_r, rstat_nxt;

  logic [LG_W-1:0]            lg;
  logic [CNT_W-1:0]           limit;

  // set-up terms
  logic signed [SLOPE_W-1:0]  su_slope;
  logic                       su_neg;
  logic                       su_par;
  logic [POS_W-1:0]           su_main_pos;
  logic [10:0]                su_pix;
  logic [10:0]                su_base;
  logic [11:0]                su_cs;
  logic signed [12:0]         su_start;
  logic signed [RAY_W-1:0]    su_main_start;
  logic signed [RAY_W-1:0]    su_main_q;
  logic signed [RAY_W-1:0]    su_diff;
  logic signed [RAY_W-1:0]    su_cs_q;
  logic signed [RAY_W-1:0]    su_slope_ext;
  logic signed [RAY_W-1:0]    su_slope_sh;

  // snap terms
  logic [POS_W-1:0]           sn_cross_pos;
  logic signed [RAY_W-1:0]    sn_cross_q;
  logic signed [PROD_W-1:0]   sn_prod_sh;
  logic signed [RAY_W-1:0]    sn_cross;

  // cell lookup
  logic [4:0]                 shamt;
  logic signed [RAY_W-1:0]    colv;
  logic signed [RAY_W-1:0]    rowv;
  logic                       col_ok;
  logic                       row_ok;
  logic [IDX_W-1:0]           cell_idx;
  logic                       cell_ok;
  logic                       at_limit;

  function automatic logic signed [HIT_W-1:0] sat_pix(input logic signed [RAY_W-1:0] v);
    logic signed [RAY_W-1:0] p;
    p = v >>> 16;
    if (p > 32767) begin
      return 16'sh7fff;
    end else if (p < -32768) begin
      return 16'sh8000;
    end
    return p[HIT_W-1:0];
  endfunction

  assign lg    = (cfg.cell_lg < MIN_LG) ? MIN_LG : cfg.cell_lg;
  assign limit = ({3'b000, cfg.max_steps} > 8'(STEP_LIMIT)) ? CNT_W'(STEP_LIMIT)
                                                          : cfg.max_steps;

  // snap to the first grid line along the stepping axis
  assign su_slope     = fam_r ? ang.slope_v : ang.slope_h;
  assign su_neg       = fam_r ? ang.neg_v : ang.neg_h;
  assign su_par       = fam_r ? ang.par_v : ang.par_h;
  assign su_main_pos  = fam_r ? px_r : py_r;
  assign su_pix       = su_main_pos[POS_W-1:4];
  assign su_base      = (su_pix >> lg) << lg;
  assign su_cs        = 12'd1 << lg;
  // up and left starts sit one pixel before the boundary
  assign su_start     = su_neg ? ({2'b00, su_base} - 13'sd1)
                               : ({2'b00, su_base} + {1'b0, su_cs});
  assign su_main_start = {{(RAY_W-29){su_start[12]}}, su_start, 16'h0000};
  assign su_main_q    = {{(RAY_W-27){1'b0}}, su_main_pos, 12'h000};
  assign su_diff      = su_main_q - su_main_start;
  assign su_cs_q      = {{(RAY_W-28){1'b0}}, su_cs, 16'h0000};
  assign su_slope_ext = {{(RAY_W-SLOPE_W){su_slope[SLOPE_W-1]}}, su_slope};
  assign su_slope_sh  = su_slope_ext <<< lg;

  assign sn_cross_pos = fam_r ? py_r : px_r;
  assign sn_cross_q   = {{(RAY_W-27){1'b0}}, sn_cross_pos, 12'h000};
  assign sn_prod_sh   = prod_r >>> 16;
  assign sn_cross     = sn_cross_q + sn_prod_sh[RAY_W-1:0];

  assign shamt    = 5'd16 + {2'b00, lg};
  assign colv     = rx_r >>> shamt;
  assign rowv     = ry_r >>> shamt;
  assign col_ok   = !colv[RAY_W-1] && (colv[RAY_W-2:5] == '0) && (colv[4:0] < cfg.map_width);
  assign row_ok   = !rowv[RAY_W-1] && (rowv[RAY_W-2:5] == '0) && (rowv[4:0] < cfg.map_height);
  assign cell_idx = IDX_W'(rowv[4:0]) * IDX_W'(cfg.map_width) + IDX_W'(colv[4:0]);
  assign cell_ok  = col_ok && row_ok && (CMP_W'(cell_idx) < CMP_W'(MAP_CELLS));
  assign at_limit = (steps_r == limit);

  assign map_rd_en   = (state_r == S_CHECK) && !at_limit && cell_ok;
  assign map_rd_addr = AW'(cell_idx);

  always_comb begin
    state_nxt      = state_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    fam_nxt        = fam_r;
    slope_nxt      = slope_r;
    diff_nxt       = diff_r;
    prod_nxt       = prod_r;
    main_nxt       = main_r;
    step_main_nxt  = step_main_r;
    step_cross_nxt = step_cross_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    steps_nxt      = steps_r;
    valid_nxt      = 1'b0;
    hx_nxt         = hx_r;
    hy_nxt         = hy_r;
    rsteps_nxt     = rsteps_r;
    rstat_nxt      = rstat_r;
    unique case (state_r)
      S_IDLE: begin
        if (cast_go) begin
          px_nxt    = player_x;
          py_nxt    = player_y;
          fam_nxt   = line_family;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (su_par) begin
          valid_nxt  = 1'b1;
          hx_nxt     = {5'b00000, px_r[POS_W-1:4]};
          hy_nxt     = {5'b00000, py_r[POS_W-1:4]};
          rsteps_nxt = '0;
          rstat_nxt  = ST_PARALLEL;
          state_nxt  = S_IDLE;
        end else begin
          slope_nxt      = su_slope;
          diff_nxt       = su_diff[DIFF_W-1:0];
          main_nxt       = su_main_start;
          step_main_nxt  = su_neg ? -su_cs_q : su_cs_q;
          step_cross_nxt = su_neg ? su_slope_sh : -su_slope_sh;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = diff_r * slope_r;
        state_nxt = S_SNAP;
      end
      S_SNAP: begin
        rx_nxt    = fam_r ? main_r : sn_cross;
        ry_nxt    = fam_r ? sn_cross : main_r;
        ox_nxt    = fam_r ? step_main_r : step_cross_r;
        oy_nxt    = fam_r ? step_cross_r : step_main_r;
        steps_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (at_limit) begin
          valid_nxt  = 1'b1;
          hx_nxt     = sat_pix(rx_r);
          hy_nxt     = sat_pix(ry_r);
          rsteps_nxt = steps_r;
          rstat_nxt  = ST_LIMIT;
          state_nxt  = S_IDLE;
        end else if (cell_ok) begin
          state_nxt = S_WAIT;
        end else begin
          // off the map: no read, step on
          rx_nxt    = rx_r + ox_r;
          ry_nxt    = ry_r + oy_r;
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_WAIT: begin
        if (map_rd_data) begin
          valid_nxt  = 1'b1;
          hx_nxt     = sat_pix(rx_r);
          hy_nxt     = sat_pix(ry_r);
          rsteps_nxt = steps_r;
          rstat_nxt  = ST_WALL;
          state_nxt  = S_IDLE;
        end else begin
          rx_nxt    = rx_r + ox_r;
          ry_nxt    = ry_r + oy_r;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    fam_r        <= fam_nxt;
    slope_r      <= slope_nxt;
    diff_r       <= diff_nxt;
    prod_r       <= prod_nxt;
    main_r       <= main_nxt;
    step_main_r  <= step_main_nxt;
    step_cross_r <= step_cross_nxt;
    rx_r         <= rx_nxt;
    ry_r         <= ry_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    steps_r      <= steps_nxt;
    hx_r         <= hx_nxt;
    hy_r         <= hy_nxt;
    rsteps_r     <= rsteps_nxt;
    rstat_r      <= rstat_nxt;
  end

  assign idle       = (state_r == S_IDLE);
  assign res_valid  = valid_r;
  assign res_hit_x  = hx_r;
  assign res_hit_y  = hy_r;
  assign res_steps  = rsteps_r;
  assign res_status = rstat_r;

endmodule

>>> design/grid_ray_wall_intersect.sv
`timescale 1ns / 1ps
// channel   handshake                       payload
// in_       start high, busy low            opcode, cell, wall, player x/y, angle, family
// out_      out_valid strobe, one cycle     hit x/y, steps taken, status
// cfg_      cfg_valid and cfg_ready high    cfg_index, cfg_data
//
// a cast runs its set-up steps in order (angle rom read, slope set-up, snap multiply,
// snap add), then walks the grid: a step that lands on the map does one map memory
// read and a step off the map does none; a ray parallel to the lines returns straight
// from slope set-up. one request at a time.
// after reset busy stays high while the wall map is swept clear.
// results cannot be held off: out_valid is high for exactly one cycle.
module grid_ray_wall_intersect #(
  parameter int MAP_CELLS   = 256,
  parameter int ANGLE_STEPS = 1024,
  parameter int STEP_LIMIT  = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [7:0]         in_cell_index,
  input  logic               in_cell_wall,
  input  logic [14:0]        in_player_x,
  input  logic [14:0]        in_player_y,
  input  logic [9:0]         in_angle_code,
  input  logic               in_line_family,
  output logic               out_valid,
  output logic signed [15:0] out_hit_x,
  output logic signed [15:0] out_hit_y,
  output logic [4:0]         out_steps_taken,
  output logic [1:0]         out_cast_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data
);
  import grw_pkg::*;

  localparam int AW = $clog2(MAP_CELLS);

  grw_cfg_t        cfg_r;
  grw_ang_t        ang;
  logic            accept;
  logic            cast_go;
  logic            wr_en;
  logic            eng_idle;
  logic            map_clearing;
  logic            map_rd_en;
  logic [AW-1:0]   map_rd_addr;
  logic            map_rd_data;

  assign accept    = start && !busy;
  assign cast_go   = accept && (in_opcode == OP_CAST);
  assign wr_en     = accept && (in_opcode == OP_WRITE);
  assign busy      = !eng_idle || map_clearing;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_width  <= 5'd10;
      cfg_r.map_height <= 5'd10;
      cfg_r.max_steps  <= 5'd10;
      cfg_r.cell_lg    <= 3'd6;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  cfg_r.map_width  <= cfg_data;
        CFG_MAP_HEIGHT: cfg_r.map_height <= cfg_data;
        CFG_MAX_STEPS:  cfg_r.max_steps  <= cfg_data;
        CFG_CELL_LG:    cfg_r.cell_lg    <= cfg_data[LG_W-1:0];
      endcase
    end
  end

  grw_tan_rom #(
    .ANGLE_STEPS(ANGLE_STEPS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (cast_go),
    .rd_addr (in_angle_code),
    .rd_data (ang)
  );

  grw_wall_map #(
    .MAP_CELLS(MAP_CELLS)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_index (in_cell_index),
    .wr_wall  (in_cell_wall),
    .rd_en    (map_rd_en),
    .rd_addr  (map_rd_addr),
    .rd_data  (map_rd_data),
    .clearing (map_clearing)
  );

  grw_ray_engine #(
    .MAP_CELLS  (MAP_CELLS),
    .STEP_LIMIT (STEP_LIMIT)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cast_go     (cast_go),
    .player_x    (in_player_x),
    .player_y    (in_player_y),
    .line_family (in_line_family),
    .cfg         (cfg_r),
    .ang         (ang),
    .map_rd_en   (map_rd_en),
    .map_rd_addr (map_rd_addr),
    .map_rd_data (map_rd_data),
    .idle        (eng_idle),
    .res_valid   (out_valid),
    .res_hit_x   (out_hit_x),
    .res_hit_y   (out_hit_y),
    .res_steps   (out_steps_taken),
    .res_status  (out_cast_status)
  );

endmodule

>>> test/grid_ray_wall_intersect_tb.sv
`timescale 1ns / 1ps

module grid_ray_wall_intersect_tb;
  import grw_pkg::*;

  typedef longint unsigned u64_t;

  localparam logic FAM_HORIZ = 1'b0;
  localparam logic FAM_VERT  = 1'b1;

  localparam int NUM_CELLS = 256;
  localparam int ANG_TURN  = 1 << ANG_W;
  localparam int ANG_QTR   = ANG_TURN / 4;
  localparam int ANG_HALF  = ANG_TURN / 2;
  localparam int MAX_COUNT = 31;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 80;

  localparam logic [ANG_W-1:0] ANG_SPECIAL [12] = '{
    10'd0, 10'd256, 10'd512, 10'd768, 10'd1, 10'd255,
    10'd257, 10'd511, 10'd513, 10'd767, 10'd769, 10'd1023
  };

  typedef struct packed {
    logic             op;
    logic [7:0]       cell_no;
    logic             wall;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [ANG_W-1:0] ang;
    logic             fam;
  } cast_req_t;

  typedef struct packed {
    logic signed [HIT_W-1:0] hit_x;
    logic signed [HIT_W-1:0] hit_y;
    logic [CNT_W-1:0]        steps;
    logic [STAT_W-1:0]       status;
  } cast_result_t;

  typedef struct packed {
    cast_req_t    req;
    logic         typed;
    cast_result_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_opcode;
  logic [7:0]         in_cell_index;
  logic               in_cell_wall;
  logic [14:0]        in_player_x;
  logic [14:0]        in_player_y;
  logic [9:0]         in_angle_code;
  logic               in_line_family;
  logic               out_valid;
  logic signed [15:0] out_hit_x;
  logic signed [15:0] out_hit_y;
  logic [4:0]         out_steps_taken;
  logic [1:0]         out_cast_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [4:0]         cfg_data;

  // predictor copy of the block state
  bit               wall_map [NUM_CELLS];
  logic [CNT_W-1:0] cur_width  = 5'd10;
  logic [CNT_W-1:0] cur_height = 5'd10;
  logic [CNT_W-1:0] cur_steps  = 5'd10;
  logic [LG_W-1:0]  cur_lg     = 3'd6;

  cast_result_t pending_hits [$];
  stim_row_t    rows [$];
  int           error_count;
  int           quiet_cycles;

  grid_ray_wall_intersect dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_cell_index   (in_cell_index),
    .in_cell_wall    (in_cell_wall),
    .in_player_x     (in_player_x),
    .in_player_y     (in_player_y),
    .in_angle_code   (in_angle_code),
    .in_line_family  (in_line_family),
    .out_valid       (out_valid),
    .out_hit_x       (out_hit_x),
    .out_hit_y       (out_hit_y),
    .out_steps_taken (out_steps_taken),
    .out_cast_status (out_cast_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [HIT_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[HIT_W-1:0];
  endfunction

  // taylor series in q30 on the reduced angle, every term truncated
  function automatic void quarter_trig(input int unsigned r, output longint sn,
                                       output longint cn);
    u64_t        x;
    u64_t        t;
    longint      acc;
    int unsigned n;
    x = (u64_t'(r) * u64_t'(HALF_PI_Q30)) / u64_t'(ANG_QTR);
    t = x;
    acc = longint'(x);
    for (n = 3; n <= 17; n += 2) begin
      t = ((t * x) >> 30) / u64_t'(n - 1);
      t = ((t * x) >> 30) / u64_t'(n);
      if ((n & 3) == 3) acc -= longint'(t);
      else acc += longint'(t);
    end
    sn = acc;
    t = u64_t'(1) << 30;
    acc = longint'(t);
    for (n = 2; n <= 16; n += 2) begin
      t = ((t * x) >> 30) / u64_t'(n - 1);
      t = ((t * x) >> 30) / u64_t'(n);
      if ((n & 3) == 2) acc -= longint'(t);
      else acc += longint'(t);
    end
    cn = acc;
  endfunction

  // -(num/den) in q16, truncated toward zero and saturated
  function automatic longint neg_slope(input longint num, input longint den);
    longint v;
    if (den == 0) return 0;
    v = (num * 65536) / den;
    if (v > SLOPE_MAX) v = SLOPE_MAX;
    if (v < -SLOPE_MAX) v = -SLOPE_MAX;
    return -v;
  endfunction

  function automatic cast_result_t trace_ray(input logic [POS_W-1:0] px,
                                             input logic [POS_W-1:0] py,
                                             input logic [ANG_W-1:0] ang,
                                             input logic fam);
    cast_result_t res;
    int unsigned  a;
    int unsigned  lg;
    int unsigned  pix_x;
    int unsigned  pix_y;
    int unsigned  taken;
    longint       s0, c0, sn, cn, slope, cs, bx, by, pxq, pyq, rx, ry, ox, oy;
    longint       col, row, idx;
    a = ang;
    pix_x = px >> 4;
    pix_y = py >> 4;
    if ((fam == FAM_HORIZ && (a == 0 || a == ANG_HALF)) ||
        (fam == FAM_VERT && (a == ANG_QTR || a == 3 * ANG_QTR))) begin
      res.hit_x  = clamp16(longint'(pix_x));
      res.hit_y  = clamp16(longint'(pix_y));
      res.steps  = '0;
      res.status = ST_PARALLEL;
      return res;
    end
    lg = (cur_lg < 3) ? 3 : cur_lg;
    cs = 64'sd1 << lg;
    quarter_trig(a % ANG_QTR, s0, c0);
    case (a / ANG_QTR)
      0: begin sn = s0;  cn = c0;  end
      1: begin sn = c0;  cn = -s0; end
      2: begin sn = -s0; cn = -c0; end
      default: begin sn = -c0; cn = s0; end
    endcase
    pxq = longint'(px) * 4096;
    pyq = longint'(py) * 4096;
    bx = longint'((pix_x >> lg) << lg);
    by = longint'((pix_y >> lg) << lg);
    if (fam == FAM_HORIZ) begin
      slope = neg_slope(cn, sn);
      // upward rays start one pixel above the cell boundary
      if (a > ANG_HALF) begin
        ry = (by - 1) * 65536;
        oy = -cs * 65536;
        ox = cs * slope;
      end else begin
        ry = (by + cs) * 65536;
        oy = cs * 65536;
        ox = -cs * slope;
      end
      rx = pxq + (((pyq - ry) * slope) >>> 16);
    end else begin
      slope = neg_slope(sn, cn);
      // leftward rays start one pixel left of the cell boundary
      if (a > ANG_QTR && a < 3 * ANG_QTR) begin
        rx = (bx - 1) * 65536;
        ox = -cs * 65536;
        oy = cs * slope;
      end else begin
        rx = (bx + cs) * 65536;
        ox = cs * 65536;
        oy = -cs * slope;
      end
      ry = pyq + (((pxq - rx) * slope) >>> 16);
    end
    taken = 0;
    res.status = ST_LIMIT;
    while (taken < ((cur_steps > MAX_COUNT) ? MAX_COUNT : cur_steps)) begin
      col = rx >>> (16 + lg);
      row = ry >>> (16 + lg);
      if (col >= 0 && row >= 0 && col < longint'(cur_width) &&
          row < longint'(cur_height)) begin
        idx = row * longint'(cur_width) + col;
        if (idx < NUM_CELLS && wall_map[idx[7:0]]) begin
          res.status = ST_WALL;
          break;
        end
      end
      rx += ox;
      ry += oy;
      taken++;
    end
    res.hit_x = clamp16(rx >>> 16);
    res.hit_y = clamp16(ry >>> 16);
    res.steps = taken[CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    cast_result_t exp_hit;
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result with no cast request waiting");
      end else begin
        exp_hit = pending_hits.pop_front();
        if (out_hit_x !== exp_hit.hit_x)
          report_mismatch($sformatf("hit_x %0d, predicted %0d", out_hit_x, exp_hit.hit_x));
        if (out_hit_y !== exp_hit.hit_y)
          report_mismatch($sformatf("hit_y %0d, predicted %0d", out_hit_y, exp_hit.hit_y));
        if (out_steps_taken !== exp_hit.steps)
          report_mismatch($sformatf("steps_taken %0d, predicted %0d", out_steps_taken,
                                    exp_hit.steps));
        if (out_cast_status !== exp_hit.status)
          report_mismatch($sformatf("cast_status %0d, predicted %0d", out_cast_status,
                                    exp_hit.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("grid_ray_wall_intersect test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves start high; the caller lowers it when it wants a gap
  task automatic send_request(input cast_req_t req, input logic typed,
                              input cast_result_t want);
    in_opcode      <= req.op;
    in_cell_index  <= req.cell_no;
    in_cell_wall   <= req.wall;
    in_player_x    <= req.x;
    in_player_y    <= req.y;
    in_angle_code  <= req.ang;
    in_line_family <= req.fam;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    if (req.op == OP_CAST)
      pending_hits.push_back(typed ? want : trace_ray(req.x, req.y, req.ang, req.fam));
    else
      wall_map[req.cell_no] = req.wall;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    // a trailing cell write may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_settings(input logic [4:0] w, input logic [4:0] h,
                                input logic [4:0] s, input logic [4:0] lgd);
    logic [1:0] regs [4];
    logic [4:0] vals [4];
    regs = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_MAX_STEPS, CFG_CELL_LG};
    vals = '{w, h, s, lgd};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_width  = w;
    cur_height = h;
    cur_steps  = s;
    cur_lg     = lgd[LG_W-1:0];
  endtask

  function automatic stim_row_t write_row(input logic [7:0] cell_no, input logic wall);
    stim_row_t row_v;
    row_v = '0;
    row_v.req.op      = OP_WRITE;
    row_v.req.cell_no = cell_no;
    row_v.req.wall    = wall;
    return row_v;
  endfunction

  function automatic stim_row_t cast_row(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                         input logic [ANG_W-1:0] ang, input logic fam);
    stim_row_t row_v;
    row_v = '0;
    row_v.req.op  = OP_CAST;
    row_v.req.x   = x;
    row_v.req.y   = y;
    row_v.req.ang = ang;
    row_v.req.fam = fam;
    return row_v;
  endfunction

  function automatic stim_row_t parallel_row(input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [ANG_W-1:0] ang, input logic fam,
                                             input logic signed [HIT_W-1:0] hx,
                                             input logic signed [HIT_W-1:0] hy);
    stim_row_t row_v;
    row_v = cast_row(x, y, ang, fam);
    row_v.typed = 1'b1;
    row_v.want  = '{hit_x: hx, hit_y: hy, steps: '0, status: ST_PARALLEL};
    return row_v;
  endfunction

  task automatic run_rows(input int first, input int last);
    for (int i = first; i < last; i++)
      send_request(rows[i].req, rows[i].typed, rows[i].want);
  endtask

  task automatic random_phase(input int count, input int idle_pct);
    cast_req_t    req;
    cast_result_t none;
    int           lg_used;
    int           cells;
    int           span_x;
    int           span_y;
    none = '0;
    for (int i = 0; i < count; i++) begin
      lg_used = (cur_lg < 3) ? 3 : cur_lg;
      req = '0;
      req.x   = POS_W'($urandom);
      req.y   = POS_W'($urandom);
      req.ang = ANG_W'($urandom);
      req.fam = 1'($urandom);
      if ($urandom_range(0, 99) < 30) begin
        req.op = OP_WRITE;
        cells = cur_width * cur_height;
        if (cells == 0 || cells > NUM_CELLS || $urandom_range(0, 7) == 0) cells = NUM_CELLS;
        req.cell_no = 8'($urandom_range(0, cells - 1));
        req.wall = ($urandom_range(0, 9) < 6);
      end else begin
        req.op      = OP_CAST;
        req.cell_no = 8'($urandom);
        req.wall    = 1'($urandom);
        // mostly start inside the map so rays cross populated cells
        if ($urandom_range(0, 7) != 0) begin
          span_x = int'(cur_width) << lg_used;
          span_y = int'(cur_height) << lg_used;
          if (span_x == 0 || span_x > 2048) span_x = 2048;
          if (span_y == 0 || span_y > 2048) span_y = 2048;
          req.x = POS_W'(($urandom_range(0, span_x - 1) << 4) | $urandom_range(0, 15));
          req.y = POS_W'(($urandom_range(0, span_y - 1) << 4) | $urandom_range(0, 15));
        end
        if ($urandom_range(0, 7) == 0) req.ang = ANG_SPECIAL[4'($urandom_range(0, 11))];
      end
      send_request(req, 1'b0, none);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  endtask

  initial begin
    int split;
    error_count  = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_WRITE;
    in_cell_index  <= '0;
    in_cell_wall   <= 1'b0;
    in_player_x    <= '0;
    in_player_y    <= '0;
    in_angle_code  <= '0;
    in_line_family <= FAM_HORIZ;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_MAP_WIDTH;
    cfg_data       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 10x10 map, 10 steps, 64 pixel cells
    rows.push_back(parallel_row(15'd0, 15'd0, 10'd0, FAM_HORIZ, 16'sd0, 16'sd0));
    rows.push_back(parallel_row(15'h7fff, 15'h7fff, 10'd512, FAM_HORIZ, 16'sd2047, 16'sd2047));
    rows.push_back(parallel_row(15'h1234, 15'h0abc, 10'd256, FAM_VERT, 16'sd291, 16'sd171));
    rows.push_back(parallel_row(15'd16, 15'd31, 10'd768, FAM_VERT, 16'sd1, 16'sd1));
    rows.push_back(cast_row(15'd1600, 15'd1600, 10'd128, FAM_HORIZ));
    rows.push_back(write_row(8'd0, 1'b1));
    rows.push_back(write_row(8'd255, 1'b1));
    rows.push_back(write_row(8'd23, 1'b1));
    rows.push_back(write_row(8'd85, 1'b1));
    rows.push_back(write_row(8'd170, 1'b0));
    // straight up from row 5 col 3 into the wall at row 2
    rows.push_back(cast_row(15'd3584, 15'd5632, 10'd768, FAM_HORIZ));
    rows.push_back(cast_row(15'd3200, 15'd3200, 10'd1023, FAM_HORIZ));
    rows.push_back(cast_row(15'd3200, 15'd3200, 10'd1, FAM_VERT));
    rows.push_back(cast_row(15'd5000, 15'd7000, 10'd257, FAM_HORIZ));
    rows.push_back(cast_row(15'd5000, 15'd7000, 10'd255, FAM_VERT));
    rows.push_back(cast_row(15'd9000, 15'd2000, 10'd513, FAM_VERT));
    rows.push_back(cast_row(15'd9000, 15'd2000, 10'd767, FAM_HORIZ));
    rows.push_back(cast_row(15'd1000, 15'd9000, 10'd769, FAM_HORIZ));
    rows.push_back(cast_row(15'd1000, 15'd9000, 10'd511, FAM_HORIZ));
    rows.push_back(cast_row(15'h7fff, 15'h7fff, 10'd0, FAM_VERT));
    rows.push_back(cast_row(15'd0, 15'd4000, 10'd512, FAM_VERT));
    rows.push_back(cast_row(15'd2000, 15'd160, 10'd700, FAM_HORIZ));
    split = rows.size();
    // zero step limit with a cell size code below the minimum
    rows.push_back(cast_row(15'd3000, 15'd3000, 10'd100, FAM_HORIZ));
    rows.push_back(cast_row(15'd3000, 15'd3000, 10'd600, FAM_VERT));
    rows.push_back(cast_row(15'h7fff, 15'd0, 10'd900, FAM_HORIZ));

    run_rows(0, split);
    settle();
    write_settings(5'd31, 5'd31, 5'd0, 5'd0);
    run_rows(split, rows.size());
    settle();

    write_settings(5'd16, 5'd16, 5'd31, 5'd7);
    random_phase(90, 30);
    settle();
    write_settings(5'd1, 5'd1, 5'd1, 5'd3);
    random_phase(50, 0);
    settle();
    write_settings(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                   5'($urandom_range(0, 31)), 5'($urandom_range(3, 7)));
    random_phase(90, 50);
    settle();
    // full register range, including codes the block clamps or ignores
    write_settings(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                   5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    random_phase(90, 20);
    settle();
    write_settings(5'($urandom_range(4, 16)), 5'($urandom_range(4, 16)),
                   5'($urandom_range(8, 31)), 5'($urandom_range(3, 7)));
    random_phase(100, 0);

    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("grid_ray_wall_intersect test passed");
    end else begin
      $display("grid_ray_wall_intersect test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/grw_pkg.sv
design/grw_tan_rom.sv
design/grw_wall_map.sv
design/grw_ray_engine.sv
design/grid_ray_wall_intersect.sv
test/grid_ray_wall_intersect_tb.sv
